// ===== design/negation_chain_value_table_defines.svh =====
// Assertion macros used by the checker file.
`ifndef NEGATION_CHAIN_VALUE_TABLE_DEFINES_SVH
`define NEGATION_CHAIN_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while dis is high
`define NCT_ASSERT_NOW(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("nct assertion failed");

// Next-cycle implication, disabled while dis is high
`define NCT_ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("nct assertion failed");

`endif

// ===== design/nct_pkg.sv =====
package nct_pkg;

    // temporary index width as seen on the ports
    localparam int IDX_W          = 8;
    localparam int IDX_COUNT      = 1 << IDX_W;
    localparam int TEMP_COUNT_DEF = 256;

    // first-holder epoch tag; tag zero is only ever written by a clearing pass
    localparam int EPOCH_W = 6;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [1:0]         t_kind;
    typedef logic [EPOCH_W-1:0] t_epoch;

    localparam t_epoch EPOCH_FIRST = t_epoch'(1);
    localparam t_epoch EPOCH_LAST  = '1;

    // instruction kinds
    localparam t_kind KIND_NONE  = 2'd0;
    localparam t_kind KIND_OTHER = 2'd1;
    localparam t_kind KIND_COPY  = 2'd2;
    localparam t_kind KIND_NEG   = 2'd3;

endpackage

// ===== design/nct_ram.sv =====
module nct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/negation_chain_value_table.sv =====
// Negation-chain value table. At steady state an instruction beat first reads
// the canonical (base, parity) entry of the source, then reads the first-holder
// entry of the resulting (base, parity), and the write-back of both tables
// overlaps the canonical read of the next beat (a same-entry overlap is
// forwarded). The two dependent memory reads keep a new beat from being taken
// before the last one is through them. Each result sits in an output
// register; a new beat is taken while it waits, and the block holds in its
// last step only while that register is still full. Canonical validity is kept
// in flip-flops and cleared by a merge point; first-holder entries carry an
// epoch tag, so the same merge point retires them all at once by bumping the
// epoch. A clearing pass over the whole first-holder memory (twice the table
// depth) runs after reset with o_in_ready low, and again each time the epoch
// count runs out, i.e. on every 63rd merge point: that beat is accepted first
// and its result comes once the pass has ended and the beat's reads are done.
module negation_chain_value_table #(
    parameter int TEMP_COUNT = nct_pkg::TEMP_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  nct_pkg::t_kind i_kind,
    input  logic          i_merge_point,
    input  nct_pkg::t_idx i_dest_index,
    input  nct_pkg::t_idx i_src_index,
    input  logic          i_same_width,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic          o_fold,
    output nct_pkg::t_idx o_copy_source,
    output nct_pkg::t_idx o_canon_base,
    output logic          o_canon_negated
);

    import nct_pkg::*;

    // only indices that fit the ports can ever be stored
    localparam int DEPTH  = (TEMP_COUNT < IDX_COUNT) ? TEMP_COUNT : IDX_COUNT;
    localparam int AW     = $clog2(DEPTH);
    localparam int HAW    = AW + 1;
    localparam int HDEPTH = 1 << HAW;
    localparam int HW     = EPOCH_W + IDX_W;
    localparam logic [HAW-1:0] CLR_LAST = HAW'(HDEPTH - 1);

    typedef enum logic [1:0] {S_IDLE, S_CLEAR, S_CANON, S_HOLD} t_state;

    function automatic logic in_range(input t_idx idx);
        return {{(32-IDX_W){1'b0}}, idx} < 32'(TEMP_COUNT);
    endfunction

    t_state r_state, n_state;

    // current item
    t_kind  r_kind;
    t_idx   r_dst;
    t_idx   r_src;
    logic   r_same;
    logic   r_act;
    logic   r_src_ok;
    logic   r_fwd;
    logic [IDX_W:0] r_fwd_word;

    // resolved canonical pair
    t_idx   r_base;
    logic   r_neg;
    logic   r_base_ok;

    // canonical validity flags
    logic [DEPTH-1:0] r_cvalid, n_cvalid;

    // first-holder epoch and clearing pass
    t_epoch         r_epoch;
    logic [HAW-1:0] r_clr_addr;
    logic           r_clr_beat;

    // output register
    logic   r_out_valid;
    logic   r_out_fold;
    t_idx   r_out_copy;
    t_idx   r_out_base;
    logic   r_out_neg;

    // datapath
    logic           in_acc;
    logic           out_free;
    logic           finish;
    logic           wrap_clr;
    logic           clearing;
    logic [IDX_W:0] canon_rdata;
    logic [IDX_W:0] canon_word;
    logic           src_hit;
    t_idx           c_base;
    logic           c_neg;
    logic [HAW-1:0] h_raddr;
    logic [HAW-1:0] h_addr_q;
    logic [HW-1:0]  hold_rdata;
    t_epoch         hold_tag;
    t_idx           hold_idx;
    logic           h_valid;
    logic           fold;
    logic           canon_we;
    logic           hold_we;
    logic           hold_wr;
    logic [HAW-1:0] hold_waddr;
    logic [HW-1:0]  hold_wdata;

    assign out_free   = !r_out_valid || i_out_ready;
    assign finish     = (r_state == S_HOLD) && out_free;
    assign o_in_ready = (r_state == S_IDLE) || finish;
    assign in_acc     = i_in_valid && o_in_ready;
    assign wrap_clr   = in_acc && i_merge_point && (r_epoch == EPOCH_LAST);
    assign clearing   = (r_state == S_CLEAR);

    // resolve the source's pair, forwarding a write-back to the same entry
    always_comb begin
        canon_word = r_fwd ? r_fwd_word : canon_rdata;
        src_hit    = r_src_ok && r_cvalid[r_src[AW-1:0]];
        case (r_kind)
            KIND_OTHER: begin
                c_base = r_dst;
                c_neg  = 1'b0;
            end
            default: begin
                if (src_hit) begin
                    c_base = canon_word[IDX_W-1:0];
                    c_neg  = canon_word[IDX_W];
                end else begin
                    c_base = r_src;
                    c_neg  = 1'b0;
                end
            end
        endcase
        if (r_kind == KIND_NEG) begin
            c_neg = ~c_neg;
        end
        h_raddr = {c_neg, c_base[AW-1:0]};
    end

    // first-holder check (tag must match the current epoch) and write-back
    always_comb begin
        h_addr_q   = {r_neg, r_base[AW-1:0]};
        hold_tag   = hold_rdata[HW-1:IDX_W];
        hold_idx   = hold_rdata[IDX_W-1:0];
        h_valid    = r_base_ok && (hold_tag == r_epoch);
        fold       = (r_kind == KIND_NEG) && r_same && h_valid && (hold_idx != r_dst);
        canon_we   = finish && r_act;
        hold_we    = finish && r_act && r_base_ok && !h_valid;
        hold_wr    = hold_we || clearing;
        hold_waddr = clearing ? r_clr_addr : h_addr_q;
        hold_wdata = clearing ? '0 : {r_epoch, r_dst};
    end

    // valid flags: a merge point on the incoming beat wins over the write-back
    always_comb begin
        n_cvalid = r_cvalid;
        if (canon_we) begin
            n_cvalid[r_dst[AW-1:0]] = 1'b1;
        end
        if (in_acc && i_merge_point) begin
            n_cvalid = '0;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = wrap_clr ? S_CLEAR : S_CANON;
                end
            end
            S_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = r_clr_beat ? S_CANON : S_IDLE;
                end
            end
            S_CANON: n_state = S_HOLD;
            S_HOLD: begin
                if (finish) begin
                    if (in_acc) begin
                        n_state = wrap_clr ? S_CLEAR : S_CANON;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cvalid    <= '0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
            r_act       <= 1'b0;
            r_epoch     <= EPOCH_FIRST;
            r_clr_addr  <= '0;
            r_clr_beat  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cvalid <= n_cvalid;

            // capture the beat
            if (in_acc) begin
                r_kind     <= i_kind;
                r_dst      <= i_dest_index;
                r_src      <= i_src_index;
                r_same     <= i_same_width;
                r_act      <= (i_kind != KIND_NONE) && in_range(i_dest_index);
                r_src_ok   <= in_range(i_src_index);
                r_fwd      <= canon_we && (i_src_index[AW-1:0] == r_dst[AW-1:0]);
                r_fwd_word <= {r_neg, r_base};
                r_clr_beat <= wrap_clr;
                if (i_merge_point) begin
                    r_epoch <= wrap_clr ? EPOCH_FIRST : t_epoch'(r_epoch + t_epoch'(1));
                end
            end

            // clearing pass address, back at zero when the pass ends
            if (clearing) begin
                r_clr_addr <= r_clr_addr + HAW'(1);
            end

            if (r_state == S_CANON) begin
                r_base    <= c_base;
                r_neg     <= c_neg;
                r_base_ok <= in_range(c_base);
            end

            // result register
            if (finish) begin
                r_out_valid <= 1'b1;
                r_out_fold  <= r_act && fold;
                r_out_copy  <= (r_act && fold) ? hold_idx : '0;
                r_out_base  <= r_act ? r_base : '0;
                r_out_neg   <= r_act && r_neg;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // canonical entry per temporary: {parity, base}
    nct_ram #(
        .WIDTH (IDX_W + 1),
        .DEPTH (DEPTH)
    ) u_canon_ram (
        .i_clk   (i_clk),
        .i_we    (canon_we),
        .i_waddr (r_dst[AW-1:0]),
        .i_wdata ({r_neg, r_base}),
        .i_re    (in_acc),
        .i_raddr (i_src_index[AW-1:0]),
        .o_rdata (canon_rdata)
    );

    // first holder per (parity, base): {epoch tag, holder}
    nct_ram #(
        .WIDTH (HW),
        .DEPTH (HDEPTH)
    ) u_hold_ram (
        .i_clk   (i_clk),
        .i_we    (hold_wr),
        .i_waddr (hold_waddr),
        .i_wdata (hold_wdata),
        .i_re    (r_state == S_CANON),
        .i_raddr (h_raddr),
        .o_rdata (hold_rdata)
    );

    assign o_out_valid     = r_out_valid;
    assign o_fold          = r_out_fold;
    assign o_copy_source   = r_out_copy;
    assign o_canon_base    = r_out_base;
    assign o_canon_negated = r_out_neg;

endmodule

// ===== design/nct_checker.sv =====
`include "negation_chain_value_table_defines.svh"

module nct_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input nct_pkg::t_kind i_kind,
    input logic          i_merge_point,
    input nct_pkg::t_idx i_dest_index,
    input nct_pkg::t_idx i_src_index,
    input logic          i_same_width,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input logic          o_fold,
    input nct_pkg::t_idx o_copy_source,
    input nct_pkg::t_idx o_canon_base,
    input logic          o_canon_negated
);

    import nct_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // reset empties the result register
    `NCT_ASSERT_NEXT(a_reset_clears, i_clk, 1'b0, !i_rst_n, !o_out_valid)

    // no beat is accepted right after another one
    `NCT_ASSERT_NEXT(a_no_back_to_back, i_clk, !i_rst_n, in_acc, !o_in_ready)

    // a stalled result holds
    `NCT_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_fold) && $stable(o_copy_source)
        && $stable(o_canon_base) && $stable(o_canon_negated))

    // copy source reads zero unless the beat folds
    `NCT_ASSERT_NOW(a_copy_zero, i_clk, !i_rst_n, o_out_valid && !o_fold,
        o_copy_source == '0)

endmodule

bind negation_chain_value_table nct_checker u_nct_checker (.*);
